### rtl/core/sbdt_pkg.sv
`default_nettype none

package sbdt_pkg;

    // Sizing
    localparam int COLOURS     = 3;
    localparam int DEPTH_BITS  = 16;
    localparam int COL_W       = (COLOURS > 2) ? $clog2(COLOURS) : 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COL_W-1:0]      COL_LAST  = COL_W'(COLOURS - 1);
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

    // Language mode register codes
    localparam logic [1:0] LANG_PASS = 2'd0;
    localparam logic [1:0] LANG_C    = 2'd1;
    localparam logic [1:0] LANG_PY   = 2'd2;

    // Token classes
    localparam logic [3:0] CLS_SPACE   = 4'd0;
    localparam logic [3:0] CLS_DIGIT   = 4'd1;
    localparam logic [3:0] CLS_NAME    = 4'd2;
    localparam logic [3:0] CLS_STRING  = 4'd3;
    localparam logic [3:0] CLS_CHAR    = 4'd4;
    localparam logic [3:0] CLS_OPEN    = 4'd5;
    localparam logic [3:0] CLS_CLOSE   = 4'd6;
    localparam logic [3:0] CLS_PUNCT   = 4'd7;
    localparam logic [3:0] CLS_COMMENT = 4'd8;
    localparam logic [3:0] CLS_HASH    = 4'd9;
    localparam logic [3:0] CLS_OTHER   = 4'd10;

    // Bracket kinds (index into the depth counters)
    localparam logic [1:0] BK_ROUND  = 2'd0;
    localparam logic [1:0] BK_CURLY  = 2'd1;
    localparam logic [1:0] BK_SQUARE = 2'd2;

    // Characters with a lexical meaning
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LCURLY = 8'h7B;
    localparam logic [7:0] CH_RCURLY = 8'h7D;
    localparam logic [7:0] CH_LSQUAR = 8'h5B;
    localparam logic [7:0] CH_RSQUAR = 8'h5D;

    // Lexer states
    typedef enum logic [11:0] {
        LM_IDLE       = 12'b0000_0000_0001,
        LM_DIGITS     = 12'b0000_0000_0010,
        LM_NAME       = 12'b0000_0000_0100,
        LM_STR        = 12'b0000_0000_1000,
        LM_STR_ESC    = 12'b0000_0001_0000,
        LM_BLK        = 12'b0000_0010_0000,
        LM_BLK_STAR   = 12'b0000_0100_0000,
        LM_LINE       = 12'b0000_1000_0000,
        LM_QOPEN1     = 12'b0001_0000_0000,
        LM_QOPEN2     = 12'b0010_0000_0000,
        LM_TRIPLE     = 12'b0100_0000_0000,
        LM_TRIPLE_ESC = 12'b1000_0000_0000
    } lex_mode_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_input;
    } src_item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic [3:0] token_class;
        logic       token_start;
        logic [1:0] bracket_color;
        logic       unbalanced;
        logic       run_last;
    } res_item_t;

    typedef struct packed {
        lex_mode_t                      mode;
        logic                           held;
        logic                           quote_kind;
        logic [1:0]                     quote_run;
        logic [2:0][DEPTH_BITS-1:0]     depth;
        logic [2:0][COL_W-1:0]          col;
    } lex_state_t;

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return b inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        return b inside {[8'd33:8'd47], [8'd58:8'd64], [8'd91:8'd96], [8'd123:8'd126]};
    endfunction

endpackage

`default_nettype wire

### rtl/core/source_lexer_bracket_depth_tagger_core.sv
// Byte-stream lexer that tags source text for C or Python highlighting.
// Source channel: src_valid/src_ready/src_data carries one byte and an
// end-of-text flag per transaction. Result channel: res_valid/res_ready/
// res_data carries one tagged byte per transaction; run_last marks the last
// result caused by a given source byte. A source byte may cause zero results
// (a C slash waiting on the next byte), one, or two (a held slash resolved).
// A byte is registered in the input stage on acceptance; its results are
// registered in the result queue before they reach the result channel.
// Throughput: one source byte per cycle while each byte gives one result and
// the receiver takes one per cycle; the result channel moves one transaction
// per cycle, so a byte giving two results takes an extra output transaction.
// A four-entry result queue decouples the sides: the input stage advances
// while the queue has room for two more results, so a stalled receiver
// backs up into src_ready after at most a few bytes, and nothing is lost.
// Configuration: cfg_wr_en writes the language mode (0 plain, 1 C, 2 Python);
// the user must write it only while idle; the block does not enforce that.
// A write returns the lexer to between tokens. Reset: mode is plain, lexer
// is between tokens, all bracket depths are zero and the queue is empty.
`default_nettype none

module source_lexer_bracket_depth_tagger_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 src_valid,
    output logic                      src_ready,
    input  wire sbdt_pkg::src_item_t  src_data,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output sbdt_pkg::res_item_t       res_data,
    input  wire logic                 cfg_wr_en,
    input  wire logic [1:0]           cfg_wr_data
);

    logic                           stage_valid_reg;
    sbdt_pkg::src_item_t            stage_item_reg;
    logic [1:0]                     lang_reg;
    sbdt_pkg::lex_state_t           state_reg;
    sbdt_pkg::lex_state_t           state_next;
    sbdt_pkg::res_item_t [1:0]      lex_res;
    logic [1:0]                     lex_cnt;
    logic                           stage_fire;
    logic                           room2;
    logic                           pop;
    logic [1:0]                     push_cnt;

    // Input stage handshake
    assign stage_fire = stage_valid_reg && room2;
    assign src_ready  = !stage_valid_reg || stage_fire;
    assign pop        = res_valid && res_ready;
    assign push_cnt   = stage_fire ? lex_cnt : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (src_ready)
            stage_valid_reg <= src_valid;
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && src_ready)
            stage_item_reg <= src_data;
    end

    // Lexing of the staged byte
    sbdt_lex u_lex (
        .lang    (lang_reg),
        .cur     (state_reg),
        .item    (stage_item_reg),
        .nxt     (state_next),
        .res     (lex_res),
        .res_cnt (lex_cnt)
    );

    // Lexer state and language mode; the user must configure only while idle (not enforced)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lang_reg             <= sbdt_pkg::LANG_PASS;
            state_reg.mode       <= sbdt_pkg::LM_IDLE;
            state_reg.held       <= 1'b0;
            state_reg.quote_kind <= 1'b0;
            state_reg.quote_run  <= 2'd0;
            state_reg.depth      <= '0;
            state_reg.col        <= '0;
        end
        else if (cfg_wr_en)
        begin
            lang_reg            <= cfg_wr_data;
            state_reg.mode      <= sbdt_pkg::LM_IDLE;
            state_reg.quote_run <= 2'd0;
        end
        else if (stage_fire)
        begin
            state_reg <= state_next;
        end
    end

    // Result queue
    sbdt_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push_data (lex_res),
        .pop       (pop),
        .head      (res_data),
        .not_empty (res_valid),
        .room2     (room2)
    );

endmodule

`default_nettype wire

### rtl/core/sbdt_lex.sv
`default_nettype none

module sbdt_lex (
    input  wire logic [1:0]              lang,
    input  wire sbdt_pkg::lex_state_t    cur,
    input  wire sbdt_pkg::src_item_t     item,
    output sbdt_pkg::lex_state_t         nxt,
    output sbdt_pkg::res_item_t [1:0]    res,
    output logic [1:0]                   res_cnt
);

    logic [7:0]                     b;
    logic                           eoi;
    logic                           c_mode;
    logic                           lexing;
    logic [7:0]                     q;
    logic [3:0]                     qcls;
    logic                           done;
    logic                           take_idle;
    logic                           set_held;
    logic                           h_emit;
    logic [3:0]                     h_cls;
    logic                           x_emit;
    logic [3:0]                     x_cls;
    logic                           x_start;
    logic [sbdt_pkg::COL_W-1:0]     x_col;
    logic                           x_unb;
    logic                           f_emit;
    logic                           bk_hit;
    logic                           bk_open;
    logic [1:0]                     bk_kind;
    logic [sbdt_pkg::DEPTH_BITS-1:0] d;
    logic [sbdt_pkg::COL_W-1:0]     cl;
    logic [sbdt_pkg::COL_W-1:0]     cl_dn;
    sbdt_pkg::res_item_t            h_item;
    sbdt_pkg::res_item_t            x_item;
    sbdt_pkg::res_item_t            f_item;
    sbdt_pkg::res_item_t            second;
    logic                           second_emit;

    // Lexing of one byte, including the resolution of a held slash
    always_comb
    begin
        b       = item.char_in;
        eoi     = item.end_of_input;
        c_mode  = (lang == sbdt_pkg::LANG_C);
        lexing  = c_mode || (lang == sbdt_pkg::LANG_PY);
        q       = cur.quote_kind ? sbdt_pkg::CH_SQUOTE : sbdt_pkg::CH_DQUOTE;
        qcls    = (c_mode && cur.quote_kind) ? sbdt_pkg::CLS_CHAR : sbdt_pkg::CLS_STRING;

        nxt       = cur;
        nxt.held  = 1'b0;
        h_emit    = cur.held;
        h_cls     = sbdt_pkg::CLS_PUNCT;
        x_emit    = 1'b0;
        x_cls     = sbdt_pkg::CLS_OTHER;
        x_start   = 1'b0;
        x_col     = '0;
        x_unb     = 1'b0;
        set_held  = 1'b0;
        done      = 1'b0;
        take_idle = 1'b0;
        bk_hit    = 1'b0;
        bk_open   = 1'b0;
        bk_kind   = sbdt_pkg::BK_ROUND;
        d         = '0;
        cl        = '0;
        cl_dn     = '0;

        // held slash followed by star or slash opens a comment
        if (cur.held && c_mode && (b == sbdt_pkg::CH_STAR || b == sbdt_pkg::CH_SLASH))
        begin
            h_cls    = sbdt_pkg::CLS_COMMENT;
            x_emit   = 1'b1;
            x_cls    = sbdt_pkg::CLS_COMMENT;
            nxt.mode = (b == sbdt_pkg::CH_STAR) ? sbdt_pkg::LM_BLK : sbdt_pkg::LM_LINE;
            done     = 1'b1;
        end

        if (!done)
        begin
            if (!lexing)
            begin
                x_emit = 1'b1;
            end
            else
            begin
                // continue the open token
                case (cur.mode)
                    sbdt_pkg::LM_IDLE:
                    begin
                        take_idle = 1'b1;
                    end
                    sbdt_pkg::LM_DIGITS:
                    begin
                        if (sbdt_pkg::is_digit(b))
                        begin
                            x_emit = 1'b1;
                            x_cls  = sbdt_pkg::CLS_DIGIT;
                        end
                        else
                        begin
                            take_idle = 1'b1;
                        end
                    end
                    sbdt_pkg::LM_NAME:
                    begin
                        if (sbdt_pkg::is_alpha(b) || sbdt_pkg::is_digit(b) ||
                            b == sbdt_pkg::CH_UNDER)
                        begin
                            x_emit = 1'b1;
                            x_cls  = sbdt_pkg::CLS_NAME;
                        end
                        else
                        begin
                            take_idle = 1'b1;
                        end
                    end
                    sbdt_pkg::LM_QOPEN1:
                    begin
                        x_emit = 1'b1;
                        x_cls  = qcls;
                        if (b == q)
                            nxt.mode = sbdt_pkg::LM_QOPEN2;
                        else if (b == sbdt_pkg::CH_BSLASH)
                            nxt.mode = sbdt_pkg::LM_STR_ESC;
                        else
                            nxt.mode = sbdt_pkg::LM_STR;
                    end
                    sbdt_pkg::LM_QOPEN2:
                    begin
                        // empty string unless a third quote follows
                        if (b != q)
                        begin
                            take_idle = 1'b1;
                        end
                        else
                        begin
                            x_emit        = 1'b1;
                            x_cls         = qcls;
                            nxt.mode      = sbdt_pkg::LM_TRIPLE;
                            nxt.quote_run = 2'd0;
                        end
                    end
                    sbdt_pkg::LM_STR:
                    begin
                        x_emit = 1'b1;
                        x_cls  = qcls;
                        if (b == q)
                            nxt.mode = sbdt_pkg::LM_IDLE;
                        else if (b == sbdt_pkg::CH_BSLASH)
                            nxt.mode = sbdt_pkg::LM_STR_ESC;
                    end
                    sbdt_pkg::LM_STR_ESC:
                    begin
                        x_emit   = 1'b1;
                        x_cls    = qcls;
                        nxt.mode = sbdt_pkg::LM_STR;
                    end
                    sbdt_pkg::LM_TRIPLE:
                    begin
                        x_emit = 1'b1;
                        x_cls  = sbdt_pkg::CLS_STRING;
                        if (b == q)
                        begin
                            if (cur.quote_run >= 2'd2)
                            begin
                                nxt.quote_run = 2'd0;
                                nxt.mode      = sbdt_pkg::LM_IDLE;
                            end
                            else
                            begin
                                nxt.quote_run = cur.quote_run + 2'd1;
                            end
                        end
                        else
                        begin
                            nxt.quote_run = 2'd0;
                            if (b == sbdt_pkg::CH_BSLASH)
                                nxt.mode = sbdt_pkg::LM_TRIPLE_ESC;
                        end
                    end
                    sbdt_pkg::LM_TRIPLE_ESC:
                    begin
                        x_emit   = 1'b1;
                        x_cls    = sbdt_pkg::CLS_STRING;
                        nxt.mode = sbdt_pkg::LM_TRIPLE;
                    end
                    sbdt_pkg::LM_BLK:
                    begin
                        x_emit = 1'b1;
                        x_cls  = sbdt_pkg::CLS_COMMENT;
                        if (b == sbdt_pkg::CH_STAR)
                            nxt.mode = sbdt_pkg::LM_BLK_STAR;
                    end
                    sbdt_pkg::LM_BLK_STAR:
                    begin
                        x_emit = 1'b1;
                        x_cls  = sbdt_pkg::CLS_COMMENT;
                        if (b == sbdt_pkg::CH_SLASH)
                            nxt.mode = sbdt_pkg::LM_IDLE;
                        else if (b != sbdt_pkg::CH_STAR)
                            nxt.mode = sbdt_pkg::LM_BLK;
                    end
                    sbdt_pkg::LM_LINE:
                    begin
                        x_emit = 1'b1;
                        x_cls  = sbdt_pkg::CLS_COMMENT;
                        if (b == sbdt_pkg::CH_NL)
                            nxt.mode = sbdt_pkg::LM_IDLE;
                    end
                    default:
                    begin
                        take_idle = 1'b1;
                    end
                endcase
            end
        end

        // start of a new token
        if (take_idle)
        begin
            nxt.mode = sbdt_pkg::LM_IDLE;
            x_start  = 1'b1;
            if (c_mode && b == sbdt_pkg::CH_SLASH)
            begin
                set_held = 1'b1;
            end
            else if (!c_mode && b == sbdt_pkg::CH_HASH)
            begin
                x_emit   = 1'b1;
                x_cls    = sbdt_pkg::CLS_COMMENT;
                nxt.mode = sbdt_pkg::LM_LINE;
            end
            else if (sbdt_pkg::is_space(b))
            begin
                x_emit = 1'b1;
                x_cls  = sbdt_pkg::CLS_SPACE;
            end
            else if (sbdt_pkg::is_digit(b))
            begin
                x_emit   = 1'b1;
                x_cls    = sbdt_pkg::CLS_DIGIT;
                nxt.mode = sbdt_pkg::LM_DIGITS;
            end
            else if (sbdt_pkg::is_alpha(b) || b == sbdt_pkg::CH_UNDER)
            begin
                x_emit   = 1'b1;
                x_cls    = sbdt_pkg::CLS_NAME;
                nxt.mode = sbdt_pkg::LM_NAME;
            end
            else if (b == sbdt_pkg::CH_DQUOTE || b == sbdt_pkg::CH_SQUOTE)
            begin
                x_emit         = 1'b1;
                nxt.quote_kind = (b == sbdt_pkg::CH_SQUOTE);
                nxt.quote_run  = 2'd0;
                x_cls          = (c_mode && b == sbdt_pkg::CH_SQUOTE) ?
                                 sbdt_pkg::CLS_CHAR : sbdt_pkg::CLS_STRING;
                nxt.mode       = c_mode ? sbdt_pkg::LM_STR : sbdt_pkg::LM_QOPEN1;
            end
            else if (b == sbdt_pkg::CH_LPAREN || b == sbdt_pkg::CH_RPAREN)
            begin
                bk_hit  = 1'b1;
                bk_kind = sbdt_pkg::BK_ROUND;
                bk_open = (b == sbdt_pkg::CH_LPAREN);
            end
            else if (b == sbdt_pkg::CH_LCURLY || b == sbdt_pkg::CH_RCURLY)
            begin
                bk_hit  = 1'b1;
                bk_kind = sbdt_pkg::BK_CURLY;
                bk_open = (b == sbdt_pkg::CH_LCURLY);
            end
            else if (b == sbdt_pkg::CH_LSQUAR || b == sbdt_pkg::CH_RSQUAR)
            begin
                bk_hit  = 1'b1;
                bk_kind = sbdt_pkg::BK_SQUARE;
                bk_open = (b == sbdt_pkg::CH_LSQUAR);
            end
            else if (c_mode && b == sbdt_pkg::CH_HASH)
            begin
                x_emit = 1'b1;
                x_cls  = sbdt_pkg::CLS_HASH;
            end
            else if (sbdt_pkg::is_punct(b))
            begin
                x_emit = 1'b1;
                x_cls  = sbdt_pkg::CLS_PUNCT;
            end
            else
            begin
                x_emit = 1'b1;
                x_cls  = sbdt_pkg::CLS_OTHER;
            end
        end

        // bracket depth and colour; colour tracks depth modulo the colour count
        if (bk_hit)
        begin
            d      = cur.depth[bk_kind];
            cl     = cur.col[bk_kind];
            cl_dn  = (cl == '0) ? sbdt_pkg::COL_LAST : (cl - sbdt_pkg::COL_W'(1));
            x_emit = 1'b1;
            if (bk_open)
            begin
                x_cls = sbdt_pkg::CLS_OPEN;
                x_col = cl;
                if (d != sbdt_pkg::DEPTH_MAX)
                begin
                    nxt.depth[bk_kind] = d + sbdt_pkg::DEPTH_BITS'(1);
                    nxt.col[bk_kind]   = (cl == sbdt_pkg::COL_LAST) ?
                                         '0 : (cl + sbdt_pkg::COL_W'(1));
                end
            end
            else if (d == '0)
            begin
                x_cls = sbdt_pkg::CLS_CLOSE;
                x_unb = 1'b1;
            end
            else
            begin
                x_cls              = sbdt_pkg::CLS_CLOSE;
                nxt.depth[bk_kind] = d - sbdt_pkg::DEPTH_BITS'(1);
                nxt.col[bk_kind]   = cl_dn;
                x_col              = cl_dn;
            end
        end

        // end of text flushes a freshly held slash
        f_emit   = set_held && eoi;
        nxt.held = set_held && !eoi;
        if (eoi)
        begin
            nxt.mode       = sbdt_pkg::LM_IDLE;
            nxt.quote_run  = 2'd0;
            nxt.quote_kind = 1'b0;
        end
    end

    // Result assembly: held slash first, then the byte or the flushed slash
    always_comb
    begin
        h_item.char_out      = sbdt_pkg::CH_SLASH;
        h_item.token_class   = h_cls;
        h_item.token_start   = 1'b1;
        h_item.bracket_color = 2'd0;
        h_item.unbalanced    = 1'b0;
        h_item.run_last      = 1'b0;

        x_item.char_out      = b;
        x_item.token_class   = x_cls;
        x_item.token_start   = x_start;
        x_item.bracket_color = 2'(x_col);
        x_item.unbalanced    = x_unb;
        x_item.run_last      = 1'b1;

        f_item.char_out      = sbdt_pkg::CH_SLASH;
        f_item.token_class   = sbdt_pkg::CLS_PUNCT;
        f_item.token_start   = 1'b1;
        f_item.bracket_color = 2'd0;
        f_item.unbalanced    = 1'b0;
        f_item.run_last      = 1'b1;

        second      = x_emit ? x_item : f_item;
        second_emit = x_emit || f_emit;

        if (h_emit)
        begin
            res[0]          = h_item;
            res[0].run_last = !second_emit;
            res[1]          = second;
            res_cnt         = second_emit ? 2'd2 : 2'd1;
        end
        else
        begin
            res[0]          = second;
            res[1]          = second;
            res[1].run_last = 1'b0;
            res_cnt         = second_emit ? 2'd1 : 2'd0;
        end
    end

endmodule

`default_nettype wire

### rtl/core/sbdt_outq.sv
`default_nettype none

module sbdt_outq (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [1:0]                   push_cnt,
    input  wire sbdt_pkg::res_item_t [1:0]    push_data,
    input  wire logic                         pop,
    output sbdt_pkg::res_item_t               head,
    output logic                              not_empty,
    output logic                              room2
);

    sbdt_pkg::res_item_t [sbdt_pkg::QUEUE_DEPTH-1:0] q_reg;
    sbdt_pkg::res_item_t [sbdt_pkg::QUEUE_DEPTH-1:0] q_next;
    logic [sbdt_pkg::QCNT_W-1:0]                     cnt_reg;
    logic [sbdt_pkg::QCNT_W-1:0]                     cnt_next;
    logic [sbdt_pkg::QCNT_W-1:0]                     after_pop;
    logic [sbdt_pkg::QIDX_W-1:0]                     wr0;
    logic [sbdt_pkg::QIDX_W-1:0]                     wr1;

    assign head      = q_reg[0];
    assign not_empty = (cnt_reg != '0);
    assign after_pop = pop ? (cnt_reg - sbdt_pkg::QCNT_W'(1)) : cnt_reg;
    assign room2     = (after_pop <= sbdt_pkg::QCNT_W'(sbdt_pkg::QUEUE_DEPTH - 2));
    assign wr0       = after_pop[sbdt_pkg::QIDX_W-1:0];
    assign wr1       = sbdt_pkg::QIDX_W'(after_pop + sbdt_pkg::QCNT_W'(1));

    // Shift toward the head on pop, then append up to two entries
    always_comb
    begin
        q_next = q_reg;
        if (pop)
        begin
            for (int i = 0; i < sbdt_pkg::QUEUE_DEPTH - 1; i++)
            begin
                q_next[i] = q_reg[i + 1];
            end
        end
        if (push_cnt != 2'd0)
            q_next[wr0] = push_data[0];
        if (push_cnt == 2'd2)
            q_next[wr1] = push_data[1];
        cnt_next = after_pop + sbdt_pkg::QCNT_W'(push_cnt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule

`default_nettype wire

### rtl/core/sbdt_checker.sv
`default_nettype none

module sbdt_checker (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 res_valid,
    input  wire logic                 res_ready,
    input  wire sbdt_pkg::res_item_t  res_data
);

    // A stalled result transaction holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // Class code stays within the defined set
    a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.token_class <= sbdt_pkg::CLS_OTHER)
        else $error("undefined token class");

    // Only brackets carry a colour
    a_color_bracket: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.token_class != sbdt_pkg::CLS_OPEN &&
        res_data.token_class != sbdt_pkg::CLS_CLOSE |-> res_data.bracket_color == 2'd0)
        else $error("colour on a non-bracket byte");

    // An unmatched close is a close bracket with colour zero
    a_unbalanced: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.unbalanced |->
        res_data.token_class == sbdt_pkg::CLS_CLOSE && res_data.bracket_color == 2'd0)
        else $error("unbalanced flag on a wrong result");

endmodule

bind source_lexer_bracket_depth_tagger_core sbdt_checker u_sbdt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
);

`default_nettype wire

### bench/lexer_tag_checker.sv
`timescale 1ns / 100ps

module lexer_tag_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    input  logic                 src_ready,
    input  sbdt_pkg::src_item_t  src_data,
    input  logic                 res_valid,
    input  logic                 res_ready,
    input  sbdt_pkg::res_item_t  res_data,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_wr_data,
    output int                   tag_mismatches,
    output int                   tags_pending
);

    localparam int REPORT_MAX = 10;

    // Shadow of the lexer state
    logic [1:0]                      lang;
    sbdt_pkg::lex_mode_t             lex_state;
    logic                            slash_held;
    logic [7:0]                      slash_byte;
    logic                            quote_single;
    logic [1:0]                      quote_count;
    logic [sbdt_pkg::DEPTH_BITS-1:0] depth [3];

    sbdt_pkg::res_item_t step_tags[$];
    sbdt_pkg::res_item_t expected_tags[$];
    int                  error_count;

    // Character classes
    function automatic logic is_num(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_mark(input logic [7:0] b);
        return (b >= 8'd33 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
               (b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126);
    endfunction

    function automatic logic [1:0] color_of(input logic [sbdt_pkg::DEPTH_BITS-1:0] d);
        logic [sbdt_pkg::DEPTH_BITS-1:0] m;
        m = d % sbdt_pkg::DEPTH_BITS'(sbdt_pkg::COLOURS);
        return m[1:0];
    endfunction

    // Single quotes are char literals only under C rules
    function automatic logic [3:0] quote_class();
        return (lang == sbdt_pkg::LANG_C && quote_single) ?
               sbdt_pkg::CLS_CHAR : sbdt_pkg::CLS_STRING;
    endfunction

    function automatic logic [7:0] quote_char();
        return quote_single ? sbdt_pkg::CH_SQUOTE : sbdt_pkg::CH_DQUOTE;
    endfunction

    function automatic void tag(input logic [7:0] ch, input logic [3:0] cls,
                                input logic first, input logic [1:0] col,
                                input logic unb);
        sbdt_pkg::res_item_t r;
        r.char_out      = ch;
        r.token_class   = cls;
        r.token_start   = first;
        r.bracket_color = col;
        r.unbalanced    = unb;
        r.run_last      = 1'b0;
        step_tags.push_back(r);
    endfunction

    // Per-kind depth: open colours then counts up, close counts down then colours
    function automatic void tag_bracket(input logic [7:0] b, input logic [1:0] kind,
                                        input logic opening);
        logic [sbdt_pkg::DEPTH_BITS-1:0] d;
        d = depth[kind];
        if (opening)
        begin
            tag(b, sbdt_pkg::CLS_OPEN, 1'b1, color_of(d), 1'b0);
            if (d != sbdt_pkg::DEPTH_MAX)
                depth[kind] = d + 1'b1;
        end
        else if (d == '0)
        begin
            tag(b, sbdt_pkg::CLS_CLOSE, 1'b1, 2'd0, 1'b1);
        end
        else
        begin
            d = d - 1'b1;
            depth[kind] = d;
            tag(b, sbdt_pkg::CLS_CLOSE, 1'b1, color_of(d), 1'b0);
        end
    endfunction

    // Byte seen between tokens
    function automatic void open_token(input logic [7:0] b);
        logic c_rules;
        c_rules = (lang == sbdt_pkg::LANG_C);
        lex_state = sbdt_pkg::LM_IDLE;
        if (c_rules && b == sbdt_pkg::CH_SLASH)
        begin
            slash_byte = b;
            slash_held = 1'b1;
        end
        else if (!c_rules && b == sbdt_pkg::CH_HASH)
        begin
            tag(b, sbdt_pkg::CLS_COMMENT, 1'b1, 2'd0, 1'b0);
            lex_state = sbdt_pkg::LM_LINE;
        end
        else if (is_blank(b))
        begin
            tag(b, sbdt_pkg::CLS_SPACE, 1'b1, 2'd0, 1'b0);
        end
        else if (is_num(b))
        begin
            tag(b, sbdt_pkg::CLS_DIGIT, 1'b1, 2'd0, 1'b0);
            lex_state = sbdt_pkg::LM_DIGITS;
        end
        else if (is_letter(b) || b == sbdt_pkg::CH_UNDER)
        begin
            tag(b, sbdt_pkg::CLS_NAME, 1'b1, 2'd0, 1'b0);
            lex_state = sbdt_pkg::LM_NAME;
        end
        else if (b == sbdt_pkg::CH_DQUOTE || b == sbdt_pkg::CH_SQUOTE)
        begin
            quote_single = (b == sbdt_pkg::CH_SQUOTE);
            quote_count  = '0;
            tag(b, quote_class(), 1'b1, 2'd0, 1'b0);
            lex_state = c_rules ? sbdt_pkg::LM_STR : sbdt_pkg::LM_QOPEN1;
        end
        else if (b == sbdt_pkg::CH_LPAREN || b == sbdt_pkg::CH_RPAREN)
        begin
            tag_bracket(b, sbdt_pkg::BK_ROUND, b == sbdt_pkg::CH_LPAREN);
        end
        else if (b == sbdt_pkg::CH_LCURLY || b == sbdt_pkg::CH_RCURLY)
        begin
            tag_bracket(b, sbdt_pkg::BK_CURLY, b == sbdt_pkg::CH_LCURLY);
        end
        else if (b == sbdt_pkg::CH_LSQUAR || b == sbdt_pkg::CH_RSQUAR)
        begin
            tag_bracket(b, sbdt_pkg::BK_SQUARE, b == sbdt_pkg::CH_LSQUAR);
        end
        else if (c_rules && b == sbdt_pkg::CH_HASH)
        begin
            tag(b, sbdt_pkg::CLS_HASH, 1'b1, 2'd0, 1'b0);
        end
        else if (is_mark(b))
        begin
            tag(b, sbdt_pkg::CLS_PUNCT, 1'b1, 2'd0, 1'b0);
        end
        else
        begin
            tag(b, sbdt_pkg::CLS_OTHER, 1'b1, 2'd0, 1'b0);
        end
    endfunction

    // Byte inside an open token; 0 means it must start a new one
    function automatic logic extend_token(input logic [7:0] b);
        logic [7:0] q;
        logic       kept;
        q    = quote_char();
        kept = 1'b1;
        case (lex_state)
            sbdt_pkg::LM_DIGITS:
            begin
                if (is_num(b))
                    tag(b, sbdt_pkg::CLS_DIGIT, 1'b0, 2'd0, 1'b0);
                else
                    kept = 1'b0;
            end
            sbdt_pkg::LM_NAME:
            begin
                if (is_letter(b) || is_num(b) || b == sbdt_pkg::CH_UNDER)
                    tag(b, sbdt_pkg::CLS_NAME, 1'b0, 2'd0, 1'b0);
                else
                    kept = 1'b0;
            end
            sbdt_pkg::LM_QOPEN1:
            begin
                tag(b, quote_class(), 1'b0, 2'd0, 1'b0);
                if (b == q)
                    lex_state = sbdt_pkg::LM_QOPEN2;
                else
                    lex_state = (b == sbdt_pkg::CH_BSLASH) ?
                                sbdt_pkg::LM_STR_ESC : sbdt_pkg::LM_STR;
            end
            sbdt_pkg::LM_QOPEN2:
            begin
                // two quotes then anything else is an empty string
                if (b != q)
                begin
                    lex_state = sbdt_pkg::LM_IDLE;
                    kept = 1'b0;
                end
                else
                begin
                    tag(b, quote_class(), 1'b0, 2'd0, 1'b0);
                    lex_state   = sbdt_pkg::LM_TRIPLE;
                    quote_count = '0;
                end
            end
            sbdt_pkg::LM_STR:
            begin
                tag(b, quote_class(), 1'b0, 2'd0, 1'b0);
                if (b == q)
                    lex_state = sbdt_pkg::LM_IDLE;
                else if (b == sbdt_pkg::CH_BSLASH)
                    lex_state = sbdt_pkg::LM_STR_ESC;
            end
            sbdt_pkg::LM_STR_ESC:
            begin
                tag(b, quote_class(), 1'b0, 2'd0, 1'b0);
                lex_state = sbdt_pkg::LM_STR;
            end
            sbdt_pkg::LM_TRIPLE:
            begin
                tag(b, sbdt_pkg::CLS_STRING, 1'b0, 2'd0, 1'b0);
                if (b == q)
                begin
                    if (quote_count == 2'd2)
                    begin
                        quote_count = '0;
                        lex_state   = sbdt_pkg::LM_IDLE;
                    end
                    else
                    begin
                        quote_count = quote_count + 1'b1;
                    end
                end
                else
                begin
                    quote_count = '0;
                    if (b == sbdt_pkg::CH_BSLASH)
                        lex_state = sbdt_pkg::LM_TRIPLE_ESC;
                end
            end
            sbdt_pkg::LM_TRIPLE_ESC:
            begin
                tag(b, sbdt_pkg::CLS_STRING, 1'b0, 2'd0, 1'b0);
                lex_state = sbdt_pkg::LM_TRIPLE;
            end
            sbdt_pkg::LM_BLK:
            begin
                tag(b, sbdt_pkg::CLS_COMMENT, 1'b0, 2'd0, 1'b0);
                if (b == sbdt_pkg::CH_STAR)
                    lex_state = sbdt_pkg::LM_BLK_STAR;
            end
            sbdt_pkg::LM_BLK_STAR:
            begin
                tag(b, sbdt_pkg::CLS_COMMENT, 1'b0, 2'd0, 1'b0);
                if (b == sbdt_pkg::CH_SLASH)
                    lex_state = sbdt_pkg::LM_IDLE;
                else if (b != sbdt_pkg::CH_STAR)
                    lex_state = sbdt_pkg::LM_BLK;
            end
            sbdt_pkg::LM_LINE:
            begin
                tag(b, sbdt_pkg::CLS_COMMENT, 1'b0, 2'd0, 1'b0);
                if (b == sbdt_pkg::CH_NL)
                    lex_state = sbdt_pkg::LM_IDLE;
            end
            default:
            begin
                lex_state = sbdt_pkg::LM_IDLE;
                kept = 1'b0;
            end
        endcase
        return kept;
    endfunction

    // Expected tags for one accepted source byte
    function automatic void predict_tags(input sbdt_pkg::src_item_t item);
        logic [7:0] b;
        logic       settled;
        b       = item.char_in;
        settled = 1'b0;
        step_tags.delete();

        // a held slash is resolved by the byte after it
        if (slash_held)
        begin
            slash_held = 1'b0;
            if (lang == sbdt_pkg::LANG_C &&
                (b == sbdt_pkg::CH_STAR || b == sbdt_pkg::CH_SLASH))
            begin
                tag(slash_byte, sbdt_pkg::CLS_COMMENT, 1'b1, 2'd0, 1'b0);
                tag(b, sbdt_pkg::CLS_COMMENT, 1'b0, 2'd0, 1'b0);
                lex_state = (b == sbdt_pkg::CH_STAR) ? sbdt_pkg::LM_BLK : sbdt_pkg::LM_LINE;
                settled   = 1'b1;
            end
            else
            begin
                tag(slash_byte, sbdt_pkg::CLS_PUNCT, 1'b1, 2'd0, 1'b0);
            end
        end

        if (!settled)
        begin
            if (lang != sbdt_pkg::LANG_C && lang != sbdt_pkg::LANG_PY)
                tag(b, sbdt_pkg::CLS_OTHER, 1'b0, 2'd0, 1'b0);
            else if (lex_state == sbdt_pkg::LM_IDLE || !extend_token(b))
                open_token(b);
        end

        // end of text flushes a slash and drops any open token
        if (item.end_of_input)
        begin
            if (slash_held)
            begin
                slash_held = 1'b0;
                tag(slash_byte, sbdt_pkg::CLS_PUNCT, 1'b1, 2'd0, 1'b0);
            end
            lex_state    = sbdt_pkg::LM_IDLE;
            quote_count  = '0;
            quote_single = 1'b0;
        end

        if (step_tags.size() > 0)
            step_tags[step_tags.size() - 1].run_last = 1'b1;
        foreach (step_tags[i])
            expected_tags.push_back(step_tags[i]);
    endfunction

    function automatic void check_tag(input sbdt_pkg::res_item_t got);
        sbdt_pkg::res_item_t want;
        if (expected_tags.size() == 0)
        begin
            if (error_count < REPORT_MAX)
                $display("unexpected tag: char %02h class %0d start %0b color %0d",
                         got.char_out, got.token_class, got.token_start,
                         got.bracket_color);
            error_count++;
        end
        else
        begin
            want = expected_tags.pop_front();
            if (got.char_out !== want.char_out || got.token_class !== want.token_class ||
                got.token_start !== want.token_start ||
                got.bracket_color !== want.bracket_color ||
                got.unbalanced !== want.unbalanced || got.run_last !== want.run_last)
            begin
                if (error_count < REPORT_MAX)
                begin
                    $display("tag mismatch (expected/actual): char %02h/%02h class %0d/%0d",
                             want.char_out, got.char_out, want.token_class, got.token_class);
                    $display("  start %0b/%0b color %0d/%0d unbalanced %0b/%0b last %0b/%0b",
                             want.token_start, got.token_start,
                             want.bracket_color, got.bracket_color,
                             want.unbalanced, got.unbalanced, want.run_last, got.run_last);
                end
                error_count++;
            end
        end
    endfunction

    // Watch config, source and result transactions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lang         = sbdt_pkg::LANG_PASS;
            lex_state    = sbdt_pkg::LM_IDLE;
            slash_held   = 1'b0;
            slash_byte   = '0;
            quote_single = 1'b0;
            quote_count  = '0;
            foreach (depth[i])
                depth[i] = '0;
            expected_tags.delete();
            error_count    = 0;
            tag_mismatches <= 0;
            tags_pending   <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                lang        = cfg_wr_data;
                lex_state   = sbdt_pkg::LM_IDLE;
                quote_count = '0;
            end
            if (src_valid && src_ready)
                predict_tags(src_data);
            if (res_valid && res_ready)
                check_tag(res_data);
            tag_mismatches <= error_count;
            tags_pending   <= expected_tags.size();
        end
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int         STALL_LIMIT   = 1000;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         PHASE_BYTES   = 50;
    localparam logic [1:0] LANG_SPARE    = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 src_valid;
    logic                 src_ready;
    sbdt_pkg::src_item_t  src_data;
    logic                 res_valid;
    logic                 res_ready;
    sbdt_pkg::res_item_t  res_data;
    logic                 cfg_wr_en;
    logic [1:0]           cfg_wr_data;

    int         tag_mismatches;
    int         tags_pending;
    int         quiet_cycles;
    logic       idling;
    logic [7:0] text_q[$];
    logic [1:0] mode_plan [6];

    source_lexer_bracket_depth_tagger_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .src_valid   (src_valid),
        .src_ready   (src_ready),
        .src_data    (src_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    lexer_tag_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .src_valid      (src_valid),
        .src_ready      (src_ready),
        .src_data       (src_data),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res_data       (res_data),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .tag_mismatches (tag_mismatches),
        .tags_pending   (tags_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Result side: random stall bursts while idling is on
    initial
    begin
        res_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (idling && $urandom_range(0, 4) == 0)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
            end
            else
            begin
                res_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any transaction
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((src_valid && src_ready) || (res_valid && res_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // One source transaction, optionally after a gap
    task automatic send_byte(input logic [7:0] b, input logic eoi);
        @(negedge clk);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= {b, eoi};    // char_in, end_of_input
        do @(posedge clk); while (!src_ready);
    endtask

    task automatic send_text(input string s, input logic eoi_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eoi_last && i == s.len() - 1);
    endtask

    // Stop the source and wait until every tag is back
    task automatic settle();
        @(negedge clk);
        src_valid <= 1'b0;
        while (tags_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        settle();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [7:0] printable();
        return 8'($urandom_range(32, 126));
    endfunction

    function automatic logic [7:0] name_char(input logic lead);
        case ($urandom_range(0, lead ? 2 : 3))
            0:       return 8'h61 + 8'($urandom_range(0, 25));
            1:       return 8'h41 + 8'($urandom_range(0, 25));
            2:       return sbdt_pkg::CH_UNDER;
            default: return 8'h30 + 8'($urandom_range(0, 9));
        endcase
    endfunction

    // String contents: escapes, stray quotes in triple strings, plain text
    function automatic void add_quoted_body(input logic [7:0] q, input logic triple);
        logic [7:0] c;
        repeat ($urandom_range(0, 5))
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    text_q.push_back(sbdt_pkg::CH_BSLASH);
                    text_q.push_back(printable());
                end
                1: text_q.push_back(triple ? q : 8'h20);
                default:
                begin
                    c = printable();
                    if (c == q || c == sbdt_pkg::CH_BSLASH)
                        c = 8'h2E;
                    text_q.push_back(c);
                end
            endcase
        end
    endfunction

    // Append one mostly well-formed token for the given language
    function automatic void add_token(input logic [1:0] m);
        logic [7:0] q;
        case ($urandom_range(0, 9))
            0: text_q.push_back($urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(9, 13)));
            1:
            begin
                repeat ($urandom_range(1, 4))
                    text_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
            end
            2, 3:
            begin
                text_q.push_back(name_char(1'b1));
                repeat ($urandom_range(0, 5))
                    text_q.push_back(name_char(1'b0));
            end
            4:
            begin
                q = $urandom_range(0, 1) ? sbdt_pkg::CH_SQUOTE : sbdt_pkg::CH_DQUOTE;
                if (m == sbdt_pkg::LANG_PY && $urandom_range(0, 2) == 0)
                begin
                    repeat (3) text_q.push_back(q);
                    add_quoted_body(q, 1'b1);
                    repeat (3) text_q.push_back(q);
                end
                else
                begin
                    text_q.push_back(q);
                    add_quoted_body(q, 1'b0);
                    text_q.push_back(q);
                end
            end
            5:
            begin
                if (m == sbdt_pkg::LANG_C && $urandom_range(0, 1))
                begin
                    text_q.push_back(sbdt_pkg::CH_SLASH);
                    text_q.push_back(sbdt_pkg::CH_STAR);
                    repeat ($urandom_range(0, 5))
                        text_q.push_back($urandom_range(0, 2) == 0 ?
                                         sbdt_pkg::CH_STAR : printable());
                    text_q.push_back(sbdt_pkg::CH_STAR);
                    text_q.push_back(sbdt_pkg::CH_SLASH);
                end
                else
                begin
                    if (m == sbdt_pkg::LANG_C)
                    begin
                        text_q.push_back(sbdt_pkg::CH_SLASH);
                        text_q.push_back(sbdt_pkg::CH_SLASH);
                    end
                    else
                    begin
                        text_q.push_back(sbdt_pkg::CH_HASH);
                    end
                    repeat ($urandom_range(0, 5))
                        text_q.push_back(printable());
                    text_q.push_back(sbdt_pkg::CH_NL);
                end
            end
            6:
            begin
                case ($urandom_range(0, 5))
                    0: text_q.push_back(sbdt_pkg::CH_LPAREN);
                    1: text_q.push_back(sbdt_pkg::CH_RPAREN);
                    2: text_q.push_back(sbdt_pkg::CH_LCURLY);
                    3: text_q.push_back(sbdt_pkg::CH_RCURLY);
                    4: text_q.push_back(sbdt_pkg::CH_LSQUAR);
                    default: text_q.push_back(sbdt_pkg::CH_RSQUAR);
                endcase
            end
            7:
            begin
                case ($urandom_range(0, 3))
                    0: text_q.push_back(8'($urandom_range(33, 47)));
                    1: text_q.push_back(8'($urandom_range(58, 64)));
                    2: text_q.push_back(8'($urandom_range(91, 96)));
                    default: text_q.push_back(8'($urandom_range(123, 126)));
                endcase
            end
            default: text_q.push_back(8'($urandom_range(0, 255)));
        endcase
    endfunction

    // Random text under one language setting
    task automatic run_phase(input logic [1:0] m, input int count);
        logic end_flag;
        int   n;
        write_mode(m);
        text_q.delete();
        while (text_q.size() < count)
            add_token(m);
        end_flag = 1'($urandom_range(0, 1));
        n = text_q.size();
        for (int i = 0; i < n; i++)
        begin
            if (i % 16 == 0)
                idling = ($urandom_range(0, 3) != 0);
            send_byte(text_q[i], ($urandom_range(0, 39) == 0) || (end_flag && i == n - 1));
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        src_valid   = 1'b0;
        src_data    = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = sbdt_pkg::LANG_PASS;
        idling      = 1'b0;
        mode_plan   = '{sbdt_pkg::LANG_C, sbdt_pkg::LANG_PY, sbdt_pkg::LANG_PASS,
                        sbdt_pkg::LANG_C, LANG_SPARE, sbdt_pkg::LANG_PY};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // pass-through extremes straight after reset
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);

        write_mode(sbdt_pkg::LANG_C);
        send_text("())", 1'b0);      // last close lands at depth zero
        send_text("/**/", 1'b0);     // block comment closed after a star run
        send_text("'\\''", 1'b0);    // char literal with an escaped quote
        send_text("#/a", 1'b0);      // C hash, then a slash that turns out punct
        send_text("/", 1'b1);        // slash flushed by end of text
        send_text("/", 1'b0);        // slash still held over the mode change

        write_mode(sbdt_pkg::LANG_PY);
        send_text("\"\"x#\n", 1'b0); // empty string, name, comment eating newline

        write_mode(LANG_SPARE);
        send_byte(8'h41, 1'b0);

        foreach (mode_plan[i])
            run_phase(mode_plan[i], PHASE_BYTES);

        // nesting past the colour count, then closes run past depth zero
        idling = 1'b0;
        write_mode(sbdt_pkg::LANG_C);
        repeat (7) send_byte(sbdt_pkg::CH_LPAREN, 1'b0);
        repeat (8) send_byte(sbdt_pkg::CH_RPAREN, 1'b0);
        send_byte(sbdt_pkg::CH_RPAREN, 1'b1);

        settle();
        repeat (8) @(posedge clk);
        if (tag_mismatches == 0 && tags_pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
